### hdl/assert_macros.svh
// ---------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros for the ray setup checkers.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property at every rising edge outside reset.
`define ASSERT_CLKD(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("%m: assertion failed");

// Check a property at every rising edge, reset included.
`define ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) (prop)) \
    else $error("%m: assertion failed");

`endif

### hdl/drs_pkg.sv
// ---------------------------------------------------------------------------
// drs_pkg
// Types, constants and coefficient table for the DDA ray setup pipeline.
// ---------------------------------------------------------------------------
`default_nettype none

package drs_pkg;

  localparam int CELL_BITS_DEF  = 10;
  localparam int ANGLE_BITS_DEF = 16;

  localparam logic [23:0] MAX24 = 24'hFF_FFFF;
  localparam logic [14:0] MAG_ONE = 15'd16384;
  // Reciprocals at or below this magnitude reach 256 cells and saturate.
  localparam logic [14:0] SAT_MAG = 15'd64;

  typedef struct packed {
    logic [15:0] angle;
    logic [25:0] pos_x;
    logic [25:0] pos_y;
  } ray_t;

  typedef struct packed {
    logic [9:0]         cell_x;
    logic [9:0]         cell_y;
    logic signed [15:0] dir_x;
    logic signed [15:0] dir_y;
    logic [23:0]        delta_x;
    logic [23:0]        delta_y;
    logic               step_neg_x;
    logic               step_neg_y;
    logic [23:0]        side_x;
    logic [23:0]        side_y;
  } setup_t;

  // Per-axis working set carried down the pipeline.
  typedef struct packed {
    logic [9:0]  tile;
    logic [15:0] frac;
    logic [1:0]  quad;
    logic [30:0] x;
    logic [30:0] x2;
    logic [31:0] p;
    logic [15:0] dir;
    logic        neg;
    logic [14:0] mag;
    logic        sat;
    logic        zero;
    logic [14:0] rem;
    logic [23:0] quo;
    logic [16:0] f;
    logic [23:0] delta;
    logic [23:0] side;
  } lane_t;

  // Lane 0 is the x axis (cosine), lane 1 the y axis (sine).
  typedef lane_t [1:0] pipe_t;

  // Taylor coefficients of sin(pi/2 x) in Q30, x^1 up to x^11.
  function automatic logic [31:0] sin_coef(input logic [2:0] idx);
    logic [31:0] c;
    begin
      case (idx)
        3'd0:    c = 32'd1686629713;
        3'd1:    c = 32'd693598668;
        3'd2:    c = 32'd85569306;
        3'd3:    c = 32'd5026995;
        3'd4:    c = 32'd172272;
        3'd5:    c = 32'd3864;
        default: c = 32'd0;
      endcase
      return c;
    end
  endfunction

endpackage

`default_nettype wire

### hdl/dda_ray_setup_top.sv
// ---------------------------------------------------------------------------
// dda_ray_setup_top
// Per-ray setup for a grid DDA raycaster: direction, cell, deltas, sides.
// ---------------------------------------------------------------------------
//  channel | signals                        | beat
//  ray     | ray_valid, ray_ready, ray      | angle, pos_x, pos_y
//  setup   | setup_valid, setup_ready, setup| cell, dir, delta, step, side
//
// Seventeen register stages; one ray may enter in every cycle unless a stall
// has filled the pipeline. The depth is set by the Horner sine chain (one
// multiply per stage) and the reciprocal divider (four quotient bits per
// stage). Reset clears the valid bits only. A stalled output holds; a stage
// with no valid beat still advances, so bubbles close up under a stall.
// ---------------------------------------------------------------------------
`default_nettype none

module dda_ray_setup_top #(
  parameter int CELL_BITS  = drs_pkg::CELL_BITS_DEF,
  parameter int ANGLE_BITS = drs_pkg::ANGLE_BITS_DEF
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           ray_valid,
  output logic                ray_ready,
  input  wire drs_pkg::ray_t  ray,
  output logic                setup_valid,
  input  wire logic           setup_ready,
  output drs_pkg::setup_t     setup
);

  localparam int NSTG    = 17;
  localparam int AB      = ANGLE_BITS;
  localparam int QUARTER = 1 << (AB - 2);
  localparam logic [25:0] PMASK = 26'((64'(1) << (CELL_BITS + 16)) - 64'(1));

  drs_pkg::pipe_t stg [NSTG];
  drs_pkg::pipe_t nxt [NSTG];
  logic [NSTG-1:0] vld;
  logic [NSTG-1:0] adv;

  // A stage moves when it is empty or the one after it moves.
  for (genvar i = 0; i < NSTG - 1; i++) begin : g_adv
    assign adv[i] = !vld[i] || adv[i+1];
  end
  assign adv[NSTG-1] = !vld[NSTG-1] || setup_ready;

  assign ray_ready = adv[0];

  for (genvar i = 0; i < NSTG; i++) begin : g_stg

    if (i == 0) begin : g_fold
      // Mask the inputs and fold each angle into the first quadrant.
      always_comb begin
        logic [AB-1:0] ang;
        logic [AB-1:0] aq;
        logic [AB-2:0] t;
        logic [25:0]   px;
        logic [25:0]   py;
        ang = AB'(ray.angle);
        px  = ray.pos_x & PMASK;
        py  = ray.pos_y & PMASK;
        nxt[i] = '0;
        nxt[i][0].tile = px[25:16];
        nxt[i][0].frac = px[15:0];
        nxt[i][1].tile = py[25:16];
        nxt[i][1].frac = py[15:0];
        for (int l = 0; l < 2; l++) begin
          aq = (l == 0) ? AB'(ang + AB'(QUARTER)) : ang;
          t  = {1'b0, aq[AB-3:0]};
          if (aq[AB-2]) begin
            t = (AB-1)'(QUARTER) - t;
          end
          nxt[i][l].quad = aq[AB-1:AB-2];
          nxt[i][l].x    = 31'(t) << (32 - AB);
        end
      end

    end else if (i == 1) begin : g_sq
      always_comb begin
        logic [63:0] prod;
        nxt[i] = stg[i-1];
        for (int l = 0; l < 2; l++) begin
          prod = 64'(stg[i-1][l].x) * 64'(stg[i-1][l].x);
          nxt[i][l].x2 = 31'(prod >> 30);
        end
      end

    end else if (i <= 6) begin : g_horner
      // One Horner step: p = c - p * x^2.
      always_comb begin
        logic [63:0] prod;
        logic [31:0] pin;
        nxt[i] = stg[i-1];
        for (int l = 0; l < 2; l++) begin
          pin  = (i == 2) ? drs_pkg::sin_coef(3'd5) : stg[i-1][l].p;
          prod = 64'(pin) * 64'(stg[i-1][l].x2);
          nxt[i][l].p = drs_pkg::sin_coef(3'(6 - i)) - 32'(prod >> 30);
        end
      end

    end else if (i == 7) begin : g_odd
      always_comb begin
        logic [63:0] prod;
        nxt[i] = stg[i-1];
        for (int l = 0; l < 2; l++) begin
          prod = 64'(stg[i-1][l].p) * 64'(stg[i-1][l].x);
          nxt[i][l].p = 32'(prod >> 30);
        end
      end

    end else if (i == 8) begin : g_round
      // Round to Q1.14, cap at one, apply the quadrant sign.
      always_comb begin
        logic [16:0] m17;
        logic [14:0] mag;
        nxt[i] = stg[i-1];
        for (int l = 0; l < 2; l++) begin
          m17 = 17'((33'(stg[i-1][l].p) + 33'(32768)) >> 16);
          mag = (m17 > 17'(drs_pkg::MAG_ONE)) ? drs_pkg::MAG_ONE : m17[14:0];
          nxt[i][l].mag  = mag;
          nxt[i][l].dir  = stg[i-1][l].quad[1] ? 16'(-$signed({1'b0, mag}))
                                                : {1'b0, mag};
          nxt[i][l].neg  = stg[i-1][l].quad[1] && (mag != '0);
          nxt[i][l].zero = (mag == '0);
          nxt[i][l].sat  = (mag <= drs_pkg::SAT_MAG);
          // The top bits of 2^30 over m leave 64 as the starting remainder.
          nxt[i][l].rem  = 15'd64;
          nxt[i][l].quo  = '0;
        end
      end

    end else if (i <= 14) begin : g_div
      // Restoring division, four quotient bits a stage.
      always_comb begin
        logic [23:0] num;
        logic [15:0] r2;
        logic [14:0] rem;
        logic [23:0] quo;
        nxt[i] = stg[i-1];
        for (int l = 0; l < 2; l++) begin
          num = 24'(stg[i-1][l].mag >> 1);
          rem = stg[i-1][l].rem;
          quo = stg[i-1][l].quo;
          for (int k = 0; k < 4; k++) begin
            r2 = {rem, num[23 - 4 * (i - 9) - k]};
            if (r2 >= {1'b0, stg[i-1][l].mag}) begin
              rem = 15'(r2 - {1'b0, stg[i-1][l].mag});
              quo = {quo[22:0], 1'b1};
            end else begin
              rem = r2[14:0];
              quo = {quo[22:0], 1'b0};
            end
          end
          nxt[i][l].rem = rem;
          nxt[i][l].quo = quo;
        end
      end

    end else if (i == 15) begin : g_delta
      always_comb begin
        nxt[i] = stg[i-1];
        for (int l = 0; l < 2; l++) begin
          nxt[i][l].delta = stg[i-1][l].sat ? drs_pkg::MAX24 : stg[i-1][l].quo;
          nxt[i][l].f = stg[i-1][l].neg ? {1'b0, stg[i-1][l].frac}
                                        : 17'h1_0000 - {1'b0, stg[i-1][l].frac};
        end
      end

    end else begin : g_side
      always_comb begin
        logic [40:0] prod;
        logic [24:0] s;
        nxt[i] = stg[i-1];
        for (int l = 0; l < 2; l++) begin
          prod = 41'(stg[i-1][l].f) * 41'(stg[i-1][l].delta);
          s    = 25'(prod >> 16);
          if (stg[i-1][l].zero || s[24]) begin
            nxt[i][l].side = drs_pkg::MAX24;
          end else begin
            nxt[i][l].side = s[23:0];
          end
        end
      end
    end

    // Payload carries no reset; the valid bit does.
    always_ff @(posedge clk) begin
      if (adv[i]) begin
        stg[i] <= nxt[i];
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[i] <= 1'b0;
      end else if (adv[i]) begin
        vld[i] <= (i == 0) ? ray_valid : vld[(i == 0) ? 0 : i - 1];
      end
    end
  end

  assign setup_valid        = vld[NSTG-1];
  assign setup.cell_x       = stg[NSTG-1][0].tile;
  assign setup.cell_y       = stg[NSTG-1][1].tile;
  assign setup.dir_x        = stg[NSTG-1][0].dir;
  assign setup.dir_y        = stg[NSTG-1][1].dir;
  assign setup.delta_x      = stg[NSTG-1][0].delta;
  assign setup.delta_y      = stg[NSTG-1][1].delta;
  assign setup.step_neg_x   = stg[NSTG-1][0].neg;
  assign setup.step_neg_y   = stg[NSTG-1][1].neg;
  assign setup.side_x       = stg[NSTG-1][0].side;
  assign setup.side_y       = stg[NSTG-1][1].side;

endmodule

`default_nettype wire

### hdl/drs_chk.sv
// ---------------------------------------------------------------------------
// drs_chk
// Port-level checks for the ray setup pipeline, bound to the top level.
// ---------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module drs_chk (
  input wire logic            clk,
  input wire logic            rst,
  input wire logic            ray_valid,
  input wire logic            ray_ready,
  input wire logic            setup_valid,
  input wire logic            setup_ready,
  input wire drs_pkg::setup_t setup
);

  logic held;
  logic zero_x;
  logic zero_ok;
  logic sign_ok;

  assign held    = setup_valid && !setup_ready;
  assign zero_x  = (setup.dir_x == 16'sd0);
  assign zero_ok = (setup.delta_x == drs_pkg::MAX24) && (setup.side_x == drs_pkg::MAX24);
  assign sign_ok = (setup.step_neg_x == setup.dir_x[15])
                && (setup.step_neg_y == setup.dir_y[15]);

  `ASSERT_CLKD(a_hold, clk, rst, held |=> setup_valid && $stable(setup))
  `ASSERT_ALWAYS(a_rst_clr, clk, rst |=> !setup_valid)
  `ASSERT_CLKD(a_sign, clk, rst, setup_valid |-> sign_ok)
  `ASSERT_CLKD(a_zero, clk, rst, setup_valid && zero_x |-> zero_ok)
  `ASSERT_CLKD(a_ready, clk, rst, ray_valid && !setup_valid |-> ray_ready)

endmodule

bind dda_ray_setup_top drs_chk u_drs_chk (
  .clk         (clk),
  .rst         (rst),
  .ray_valid   (ray_valid),
  .ray_ready   (ray_ready),
  .setup_valid (setup_valid),
  .setup_ready (setup_ready),
  .setup       (setup)
);

`default_nettype wire
